// ===== src/sahp_pkg.sv =====
`default_nettype none
package sahp_pkg;

  // fixed field widths
  localparam int ADDR_W  = 64;
  localparam int COUNT_W = 32;

  // hash: (address >> 4) reduced one 4-bit digit per cycle, MSB first
  localparam int HASH_SHIFT = 4;
  localparam int HASH_BITS  = ADDR_W - HASH_SHIFT;
  localparam int HASH_DIGIT = 4;
  localparam int HASH_STEPS = HASH_BITS / HASH_DIGIT;
  localparam int HASH_CNT_W = $clog2(HASH_STEPS + 1);

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;

  // sample status codes
  localparam logic [2:0] ST_DISABLED = 3'd0;
  localparam logic [2:0] ST_NOT_HELD = 3'd1;
  localparam logic [2:0] ST_HIT      = 3'd2;
  localparam logic [2:0] ST_INSERTED = 3'd3;
  localparam logic [2:0] ST_LOST     = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_EMIT_STATUS,
    S_SCAN,
    S_EMIT_HDR,
    S_EMIT_ENT,
    S_TAKE,
    S_NEXT,
    S_EMIT_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       cnt_sample;
    logic       cnt_held;
    logic       cnt_lost;
    logic       set_status;
    logic [2:0] status;
    logic       hash_start;
    logic       hash_step;
    logic       probe_init;
    logic       probe_next;
    logic       hit_write;
    logic       ins_write;
    logic       clr_step;
    logic       rank_init;
    logic       scan_init;
    logic       scan_step;
    logic       take;
    logic       emit_status;
    logic       emit_header;
    logic       emit_entry;
    logic       emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enabled;
    logic mode;
    logic held;
    logic sample_zero;
    logic hash_done;
    logic probe_match;
    logic probe_empty;
    logic probe_last;
    logic cnt_end;
    logic scan_done;
    logic found;
    logic rank_zero;
    logic rank_full;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/sahp_if.sv =====
`default_nettype none
// sample channel
interface sahp_in_if import sahp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic              owner_present;
  logic [ADDR_W-1:0] return_address;

  modport source(output valid, mode, owner_present, return_address, input ready);
  modport sink(input valid, mode, owner_present, return_address, output ready);
endinterface

// result channel
interface sahp_out_if import sahp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         sample_status;
  logic [ADDR_W-1:0]  entry_address;
  logic [COUNT_W-1:0] entry_hits;
  logic [COUNT_W-1:0] total_samples;
  logic [COUNT_W-1:0] total_held;
  logic [COUNT_W-1:0] total_lost;
  logic               last;

  modport source(output valid, kind, sample_status, entry_address, entry_hits,
                 total_samples, total_held, total_lost, last, input ready);
  modport sink(input valid, kind, sample_status, entry_address, entry_hits,
               total_samples, total_held, total_lost, last, output ready);
endinterface
`default_nettype wire

// ===== src/sampled_address_hit_profiler.sv =====
`default_nettype none
// Sample: a held sample's address is hashed, then the table is probed, a read and a compare
//   per probe; one item at a time; throughput set by the hash unit and single table port.
// Report: one full table scan per ranked entry.
// Reset (synchronous, active high) runs a clearing pass over every slot of the slot
//   tables; no sample is taken until it ends, config writes are taken throughout.
module sampled_address_hit_profiler import sahp_pkg::*; #(
  parameter int SLOT_COUNT   = 64,
  parameter int PROBE_LIMIT  = 8,
  parameter int REPORT_DEPTH = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write,
  input  wire logic  cfg_wdata,
  sahp_in_if.sink    sample_in,
  sahp_out_if.source result_out
);

  cmd_t  cmd;
  stat_t stat;

  // controller
  sahp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (sample_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath with slot tables
  sahp_datapath #(
    .SLOT_COUNT   (SLOT_COUNT),
    .PROBE_LIMIT  (PROBE_LIMIT),
    .REPORT_DEPTH (REPORT_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_wdata   (cfg_wdata),
    .in_mode     (sample_in.mode),
    .in_owner    (sample_in.owner_present),
    .in_addr     (sample_in.return_address),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_kind    (result_out.kind),
    .out_status  (result_out.sample_status),
    .out_addr    (result_out.entry_address),
    .out_hits    (result_out.entry_hits),
    .out_samples (result_out.total_samples),
    .out_held    (result_out.total_held),
    .out_lost    (result_out.total_lost),
    .out_last    (result_out.last)
  );

`ifndef NO_ASSERTIONS
  // a sample produces exactly one result
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.kind == KIND_STATUS |-> result_out.last)
    else $error("sample status result without last");

  // only nonzero counts are ranked
  a_entry_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.kind == KIND_ENTRY |-> result_out.entry_hits != '0)
    else $error("ranked entry with zero hits");

  // totals ride on the header alone
  a_totals_header: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.kind != KIND_HEADER |->
      result_out.total_samples == '0 && result_out.total_held == '0 &&
      result_out.total_lost == '0)
    else $error("totals on a non-header result");

  // no new sample is taken while a report or probe is in flight
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    sample_in.valid && sample_in.ready |=> !sample_in.ready)
    else $error("sample taken while busy");
`endif

endmodule
`default_nettype wire

// ===== src/sahp_ctrl.sv =====
`default_nettype none
module sahp_ctrl import sahp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (stat.cnt_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.mode) begin
          // report: nothing at all when no sample was ever counted
          if (stat.sample_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.rank_init = 1'b1;
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end else if (!stat.enabled) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DISABLED;
          state_next     = S_EMIT_STATUS;
        end else if (!stat.held) begin
          cmd.cnt_sample = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_HELD;
          state_next     = S_EMIT_STATUS;
        end else begin
          cmd.cnt_sample = 1'b1;
          cmd.cnt_held   = 1'b1;
          cmd.hash_start = 1'b1;
          state_next     = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.hash_done) begin
          cmd.probe_init = 1'b1;
          state_next     = S_PROBE_RD;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_PROBE_RD: begin
        state_next = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        priority if (stat.probe_match) begin
          cmd.hit_write  = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_HIT;
          state_next     = S_EMIT_STATUS;
        end else if (stat.probe_empty) begin
          cmd.ins_write  = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_INSERTED;
          state_next     = S_EMIT_STATUS;
        end else if (stat.probe_last) begin
          cmd.cnt_lost   = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_LOST;
          state_next     = S_EMIT_STATUS;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_PROBE_RD;
        end
      end
      S_EMIT_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = stat.rank_zero ? S_EMIT_HDR : S_EMIT_ENT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT_HDR: begin
        if (stat.out_free) begin
          cmd.emit_header = 1'b1;
          cmd.emit_last   = !stat.found;
          state_next      = stat.found ? S_TAKE : S_IDLE;
        end
      end
      S_EMIT_ENT: begin
        // previous entry goes out once we know whether another follows
        if (stat.out_free) begin
          cmd.emit_entry = 1'b1;
          cmd.emit_last  = !stat.found;
          state_next     = stat.found ? S_TAKE : S_IDLE;
        end
      end
      S_TAKE: begin
        cmd.take   = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (stat.rank_full) begin
          state_next = S_EMIT_FINAL;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_EMIT_FINAL: begin
        if (stat.out_free) begin
          cmd.emit_entry = 1'b1;
          cmd.emit_last  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/sahp_datapath.sv =====
`default_nettype none
module sahp_datapath import sahp_pkg::*; #(
  parameter int SLOT_COUNT   = 64,
  parameter int PROBE_LIMIT  = 8,
  parameter int REPORT_DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic               cfg_write,
  input  wire logic               cfg_wdata,
  input  wire logic               in_mode,
  input  wire logic               in_owner,
  input  wire logic [ADDR_W-1:0]  in_addr,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic [2:0]              out_status,
  output logic [ADDR_W-1:0]       out_addr,
  output logic [COUNT_W-1:0]      out_hits,
  output logic [COUNT_W-1:0]      out_samples,
  output logic [COUNT_W-1:0]      out_held,
  output logic [COUNT_W-1:0]      out_lost,
  output logic                    out_last
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int PW = $clog2(PROBE_LIMIT + 1);
  localparam int RW = $clog2(REPORT_DEPTH + 1);
  localparam logic [IW:0]   SLOT_N    = (IW + 1)'(SLOT_COUNT);
  localparam logic [IW-1:0] SLOT_LAST = IW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] SCAN_END  = CW'(SLOT_COUNT);

  // slot tables
  logic [ADDR_W-1:0]  mem_addr [SLOT_COUNT];
  logic [COUNT_W-1:0] mem_hits [SLOT_COUNT];
  logic [ADDR_W-1:0]  rd_addr_q;
  logic [COUNT_W-1:0] rd_hits_q;
  logic [IW-1:0]      rd_idx;
  logic               rd_en;
  logic               wr_a, wr_h;
  logic [IW-1:0]      wr_idx;
  logic [ADDR_W-1:0]  wr_a_data;
  logic [COUNT_W-1:0] wr_h_data;

  // item and totals
  logic               enabled;
  logic               mode_q, owner_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [COUNT_W-1:0] samples, held, lost;
  logic [2:0]         status_q;

  // hash unit
  logic [HASH_BITS-1:0]  hash_val;
  logic [IW-1:0]         hash_rem, hash_rem_next;
  logic [IW:0]           hash_trial;
  logic [HASH_CNT_W-1:0] hash_cnt;

  // probe
  logic [IW-1:0] idx;
  logic [PW-1:0] probe_cnt;

  // ranking scan
  logic [CW-1:0]      scan_cnt;
  logic               cmp_valid;
  logic [IW-1:0]      cmp_idx;
  logic               found;
  logic [IW-1:0]      best_idx;
  logic [COUNT_W-1:0] best_hits;
  logic [ADDR_W-1:0]  best_addr;
  logic [ADDR_W-1:0]  pend_addr;
  logic [COUNT_W-1:0] pend_hits;
  logic [RW-1:0]      rank;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_write) begin
      enabled <= cfg_wdata;
    end
  end

  // capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= in_mode;
      owner_q <= in_owner;
      addr_q  <= in_addr;
    end
    if (cmd.set_status) begin
      status_q <= cmd.status;
    end
  end

  // totals, wrapping
  always_ff @(posedge clk) begin
    if (rst) begin
      samples <= '0;
      held    <= '0;
      lost    <= '0;
    end else begin
      if (cmd.cnt_sample) samples <= samples + 1'b1;
      if (cmd.cnt_held)   held    <= held + 1'b1;
      if (cmd.cnt_lost)   lost    <= lost + 1'b1;
    end
  end

  // one step of restoring remainder per bit, HASH_DIGIT bits a cycle
  always_comb begin
    hash_rem_next = hash_rem;
    hash_trial    = '0;
    for (int j = 0; j < HASH_DIGIT; j++) begin
      hash_trial = {hash_rem_next, hash_val[HASH_BITS-1-j]};
      if (hash_trial >= SLOT_N) begin
        hash_trial = hash_trial - SLOT_N;
      end
      hash_rem_next = hash_trial[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_cnt <= '0;
    end else if (cmd.hash_start) begin
      hash_val <= addr_q[ADDR_W-1:HASH_SHIFT];
      hash_rem <= '0;
      hash_cnt <= '0;
    end else if (cmd.hash_step) begin
      hash_val <= hash_val << HASH_DIGIT;
      hash_rem <= hash_rem_next;
      hash_cnt <= hash_cnt + 1'b1;
    end
  end

  // probe pointer, wraps at the last slot
  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      idx       <= hash_rem;
      probe_cnt <= '0;
    end else if (cmd.probe_next) begin
      idx       <= (idx == SLOT_LAST) ? '0 : idx + 1'b1;
      probe_cnt <= probe_cnt + 1'b1;
    end
  end

  // slot counter: clearing pass after reset and ranking scan
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt  <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.scan_init) begin
      scan_cnt  <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (cmd.scan_step) begin
        if (scan_cnt != SCAN_END) begin
          scan_cnt  <= scan_cnt + 1'b1;
          cmp_valid <= 1'b1;
          cmp_idx   <= scan_cnt[IW-1:0];
        end else begin
          cmp_valid <= 1'b0;
        end
      end
      // strict greater keeps the lowest slot on a tie
      if (cmp_valid && rd_hits_q != '0 && (!found || rd_hits_q > best_hits)) begin
        found     <= 1'b1;
        best_idx  <= cmp_idx;
        best_hits <= rd_hits_q;
        best_addr <= rd_addr_q;
      end
    end
  end

  // rank counter and the entry waiting to go out
  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= '0;
    end else if (cmd.rank_init) begin
      rank <= '0;
    end else if (cmd.take) begin
      rank <= rank + 1'b1;
    end
    if (cmd.take) begin
      pend_addr <= best_addr;
      pend_hits <= best_hits;
    end
  end

  // table ports
  always_comb begin
    rd_idx = cmd.scan_step ? scan_cnt[IW-1:0] : idx;
    rd_en  = cmd.scan_step ? (scan_cnt != SCAN_END) : 1'b1;
  end

  always_comb begin
    wr_a      = 1'b0;
    wr_h      = 1'b0;
    wr_idx    = idx;
    wr_a_data = addr_q;
    wr_h_data = rd_hits_q + 1'b1;
    priority if (cmd.clr_step) begin
      wr_a      = 1'b1;
      wr_h      = 1'b1;
      wr_idx    = scan_cnt[IW-1:0];
      wr_a_data = '0;
      wr_h_data = '0;
    end else if (cmd.hit_write) begin
      wr_h = 1'b1;
    end else if (cmd.ins_write) begin
      wr_a      = 1'b1;
      wr_h      = 1'b1;
      wr_h_data = COUNT_W'(1);
    end else if (cmd.take) begin
      wr_h      = 1'b1;
      wr_idx    = best_idx;
      wr_h_data = '0;
    end else begin
      wr_a = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) mem_addr[wr_idx] <= wr_a_data;
    if (wr_h) mem_hits[wr_idx] <= wr_h_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_q <= mem_addr[rd_idx];
      rd_hits_q <= mem_hits[rd_idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_status || cmd.emit_header || cmd.emit_entry) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status || cmd.emit_header || cmd.emit_entry) begin
      out_kind    <= KIND_STATUS;
      out_status  <= '0;
      out_addr    <= '0;
      out_hits    <= '0;
      out_samples <= '0;
      out_held    <= '0;
      out_lost    <= '0;
      out_last    <= 1'b1;
      priority if (cmd.emit_status) begin
        out_status <= status_q;
      end else if (cmd.emit_header) begin
        out_kind    <= KIND_HEADER;
        out_samples <= samples;
        out_held    <= held;
        out_lost    <= lost;
        out_last    <= cmd.emit_last;
      end else begin
        out_kind <= KIND_ENTRY;
        out_addr <= pend_addr;
        out_hits <= pend_hits;
        out_last <= cmd.emit_last;
      end
    end
  end

  // status
  always_comb begin
    stat.enabled     = enabled;
    stat.mode        = mode_q;
    stat.held        = owner_q && (addr_q != '0);
    stat.sample_zero = (samples == '0);
    stat.hash_done   = (hash_cnt == HASH_CNT_W'(HASH_STEPS));
    stat.probe_match = (rd_addr_q == addr_q);
    stat.probe_empty = (rd_addr_q == '0);
    stat.probe_last  = (probe_cnt == PW'(PROBE_LIMIT - 1));
    stat.cnt_end     = (scan_cnt == SCAN_END);
    stat.scan_done   = (scan_cnt == SCAN_END) && !cmp_valid;
    stat.found       = found;
    stat.rank_zero   = (rank == '0);
    stat.rank_full   = (rank == RW'(REPORT_DEPTH));
    stat.out_free    = !out_valid || out_ready;
  end

endmodule
`default_nettype wire
